// ----- hw/rtl/aabb_table_ground_probe_macros.svh -----
// Assertion macros for the box table ground probe.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef AABB_TABLE_GROUND_PROBE_MACROS_SVH
`define AABB_TABLE_GROUND_PROBE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ATGP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ATGP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/atgp_pkg.sv -----
// Package for the box table ground probe: item types, box layout and constants.
// No dependencies; used by atgp_cmp_unit and the top level.
package atgp_pkg;

	localparam int MAX_OBJ = 64;
	localparam int IDX_W   = $clog2(MAX_OBJ);
	localparam int CNT_W   = $clog2(MAX_OBJ + 1);
	localparam int CW      = 34;
	localparam int BOX_W   = 6 * 32;
	localparam int LANES   = 6;

	typedef logic signed [31:0]   coord_t;
	typedef logic signed [CW-1:0] wcoord_t;

	localparam wcoord_t FX_0P2 = CW'(13107);
	localparam wcoord_t FX_0P5 = CW'(32768);
	localparam wcoord_t FX_0P1 = CW'(6554);

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_GROUND = 2'd1;
	localparam logic [1:0] CMD_CLASS  = 2'd2;
	localparam logic [1:0] CMD_PAIR   = 2'd3;

	localparam logic [1:0] CLS_NONE   = 2'd0;
	localparam logic [1:0] CLS_INSIDE = 2'd1;
	localparam logic [1:0] CLS_ABOVE  = 2'd2;
	localparam logic [1:0] CLS_BELOW  = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] obj_index;
		logic [5:0] second_index;
		coord_t     pos_x;
		coord_t     pos_y;
		coord_t     pos_z;
		logic       last_vertex;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] ground_index;
		logic       ground_found;
		logic [1:0] cam_class;
		logic       pair_overlap;
	} out_item_t;

	// Axis 0 is x, 1 is y, 2 is z.
	typedef struct packed {
		coord_t [2:0] lo;
		coord_t [2:0] hi;
	} box_t;

	typedef struct packed {
		wcoord_t [LANES-1:0] lhs;
		wcoord_t [LANES-1:0] rhs;
	} cmp_req_t;

	typedef struct packed {
		logic [LANES-1:0] le;
	} cmp_rsp_t;

	function automatic wcoord_t sx(input coord_t v);
		sx = {{(CW - 32){v[31]}}, v};
	endfunction

endpackage

// ----- hw/rtl/atgp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atgp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/atgp_cmp_unit.sv -----
// Shared compare unit: six signed less-or-equal tests on widened coordinates.
// Depends on atgp_pkg.
module atgp_cmp_unit (
	input  atgp_pkg::cmp_req_t req,
	output atgp_pkg::cmp_rsp_t rsp
);

	always_comb begin
		for (int k = 0; k < atgp_pkg::LANES; k++) begin
			rsp.le[k] = $signed(req.lhs[k]) <= $signed(req.rhs[k]);
		end
	end

endmodule

// ----- hw/rtl/aabb_table_ground_probe.sv -----
// Top level of the box table ground probe: sequencer, camera box and table.
// Depends on atgp_pkg, atgp_ram, atgp_cmp_unit and the assertion macro header.
//
//   channel   direction  signals                      handshake
//   item      in         start, busy, item            taken when start and not busy
//   result    out        done, result                 one cycle, cannot be stalled
//   config    in         cfg_we, cfg_data             written when cfg_we is high
//
// A load writes the first vertex of a box as a new entry (ST_WR_NEW) and otherwise
// reads the entry and merges the vertex into it (ST_RD, ST_MERGE); a classify runs
// ST_RD and ST_CLASS, a pair test ST_RD, ST_RD2 and ST_PAIR. A ground query reads
// min(object_count, 64) entries, one table read per object through the single read port.
// Busy stays high until the item ends, for a query until its result strobe; the
// next item may start in that cycle. Reset clears registers; the table needs none.
`include "aabb_table_ground_probe_macros.svh"

module aabb_table_ground_probe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  atgp_pkg::in_item_t  item,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_data,
	output logic                done,
	output atgp_pkg::out_item_t result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_NEW,
		ST_RD,
		ST_MERGE,
		ST_CLASS,
		ST_RD2,
		ST_PAIR,
		ST_SCAN
	} state_t;

	state_t                         state_q;
	logic                           pending_q;
	logic [6:0]                     count_q;
	logic [1:0]                     cmd_q;
	logic [atgp_pkg::IDX_W-1:0]     idx_q;
	logic [atgp_pkg::IDX_W-1:0]     idx2_q;
	atgp_pkg::coord_t [2:0]         pos_q;
	atgp_pkg::wcoord_t [2:0]        cam_lo_q;
	atgp_pkg::wcoord_t [2:0]        cam_hi_q;
	atgp_pkg::wcoord_t              cam_gnd_q;
	atgp_pkg::box_t                 pair_a_q;
	logic [atgp_pkg::CNT_W-1:0]     n_q;
	logic [atgp_pkg::CNT_W-1:0]     rd_cnt_q;
	logic                           vld_s1;
	logic [atgp_pkg::IDX_W-1:0]     idx_s1;
	logic                           found_q;
	logic [atgp_pkg::IDX_W-1:0]     best_q;
	atgp_pkg::coord_t               best_top_q;
	logic                           done_q;
	atgp_pkg::out_item_t            res_q;

	logic                           ram_we;
	logic [atgp_pkg::IDX_W-1:0]     ram_waddr;
	atgp_pkg::box_t                 ram_wbox;
	logic                           ram_re;
	logic [atgp_pkg::IDX_W-1:0]     ram_raddr;
	logic [atgp_pkg::BOX_W-1:0]     ram_rdata;
	atgp_pkg::box_t                 ent;
	atgp_pkg::cmp_req_t             creq;
	atgp_pkg::cmp_rsp_t             crsp;
	logic                           issue;
	logic                           xz_ov;
	logic                           qualify;
	logic [1:0]                     cls;
	logic [6:0]                     n_clip;
	atgp_pkg::wcoord_t [2:0]        in_w;

	assign ent  = atgp_pkg::box_t'(ram_rdata);
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = res_q;

	assign issue  = (rd_cnt_q < n_q);
	assign n_clip = (count_q > 7'(atgp_pkg::MAX_OBJ)) ? 7'(atgp_pkg::MAX_OBJ) : count_q;

	assign in_w[0] = atgp_pkg::sx(item.pos_x);
	assign in_w[1] = atgp_pkg::sx(item.pos_y);
	assign in_w[2] = atgp_pkg::sx(item.pos_z);

	atgp_ram #(
		.WIDTH(atgp_pkg::BOX_W),
		.DEPTH(atgp_pkg::MAX_OBJ)
	) u_box_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wbox),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	atgp_cmp_unit u_cmp (
		.req(creq),
		.rsp(crsp)
	);

	// Lane k tests the low side of axis k, lane k+3 the high side.
	always_comb begin
		creq = '0;
		for (int k = 0; k < 3; k++) begin
			case (state_q)
				ST_MERGE: begin
					creq.lhs[k]     = atgp_pkg::sx(ent.lo[k]);
					creq.rhs[k]     = atgp_pkg::sx(pos_q[k]);
					creq.lhs[k + 3] = atgp_pkg::sx(pos_q[k]);
					creq.rhs[k + 3] = atgp_pkg::sx(ent.hi[k]);
				end
				ST_CLASS, ST_SCAN: begin
					creq.lhs[k]     = atgp_pkg::sx(ent.lo[k]);
					creq.rhs[k]     = cam_hi_q[k];
					creq.lhs[k + 3] = cam_lo_q[k];
					creq.rhs[k + 3] = atgp_pkg::sx(ent.hi[k]);
				end
				ST_PAIR: begin
					creq.lhs[k]     = atgp_pkg::sx(pair_a_q.lo[k]);
					creq.rhs[k]     = atgp_pkg::sx(ent.hi[k]);
					creq.lhs[k + 3] = atgp_pkg::sx(ent.lo[k]);
					creq.rhs[k + 3] = atgp_pkg::sx(pair_a_q.hi[k]);
				end
				default: begin
					creq.lhs[k]     = '0;
					creq.rhs[k]     = '0;
					creq.lhs[k + 3] = '0;
					creq.rhs[k + 3] = '0;
				end
			endcase
		end
		// The ground scan uses the y lanes for the height tests instead.
		if (state_q == ST_SCAN) begin
			creq.lhs[1] = atgp_pkg::sx(ent.hi[1]);
			creq.rhs[1] = atgp_pkg::sx(best_top_q);
			creq.lhs[4] = cam_gnd_q;
			creq.rhs[4] = atgp_pkg::sx(ent.hi[1]);
		end
	end

	assign xz_ov   = crsp.le[0] && crsp.le[3] && crsp.le[2] && crsp.le[5];
	assign qualify = xz_ov && !crsp.le[4] && (!found_q || !crsp.le[1]);

	always_comb begin
		if (xz_ov && crsp.le[1] && crsp.le[4]) begin
			cls = atgp_pkg::CLS_INSIDE;
		end else if (xz_ov && !crsp.le[4]) begin
			cls = atgp_pkg::CLS_ABOVE;
		end else if (xz_ov) begin
			cls = atgp_pkg::CLS_BELOW;
		end else begin
			cls = atgp_pkg::CLS_NONE;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wbox  = '0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		for (int k = 0; k < 3; k++) begin
			ram_wbox.lo[k] = pos_q[k];
			ram_wbox.hi[k] = pos_q[k];
		end
		case (state_q)
			ST_WR_NEW: begin
				ram_we = 1'b1;
			end
			ST_RD: begin
				ram_re = 1'b1;
			end
			ST_MERGE: begin
				ram_we = 1'b1;
				for (int k = 0; k < 3; k++) begin
					ram_wbox.lo[k] = crsp.le[k] ? ent.lo[k] : pos_q[k];
					ram_wbox.hi[k] = crsp.le[k + 3] ? ent.hi[k] : pos_q[k];
				end
			end
			ST_RD2: begin
				ram_re    = 1'b1;
				ram_raddr = idx2_q;
			end
			ST_SCAN: begin
				ram_re    = issue;
				ram_raddr = rd_cnt_q[atgp_pkg::IDX_W-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pending_q  <= 1'b1;
			count_q    <= '0;
			cmd_q      <= atgp_pkg::CMD_LOAD;
			idx_q      <= '0;
			idx2_q     <= '0;
			pos_q      <= '0;
			cam_lo_q   <= '0;
			cam_hi_q   <= '0;
			cam_gnd_q  <= '0;
			pair_a_q   <= '0;
			n_q        <= '0;
			rd_cnt_q   <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			best_top_q <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			done_q <= (state_q == ST_CLASS) || (state_q == ST_PAIR) ||
				((state_q == ST_SCAN) && !issue && !vld_s1);
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q     <= item.command;
						idx_q     <= item.obj_index;
						idx2_q    <= item.second_index;
						pos_q[0]  <= item.pos_x;
						pos_q[1]  <= item.pos_y;
						pos_q[2]  <= item.pos_z;
						cam_lo_q[0] <= in_w[0] - atgp_pkg::FX_0P2;
						cam_lo_q[1] <= in_w[1] - atgp_pkg::FX_0P5;
						cam_lo_q[2] <= in_w[2] - atgp_pkg::FX_0P2;
						cam_hi_q[0] <= in_w[0] + atgp_pkg::FX_0P2;
						cam_hi_q[1] <= in_w[1] + atgp_pkg::FX_0P2;
						cam_hi_q[2] <= in_w[2] + atgp_pkg::FX_0P2;
						cam_gnd_q   <= in_w[1] - atgp_pkg::FX_0P5 + atgp_pkg::FX_0P1;
						case (item.command)
							atgp_pkg::CMD_LOAD: begin
								pending_q <= item.last_vertex;
								state_q   <= pending_q ? ST_WR_NEW : ST_RD;
							end
							atgp_pkg::CMD_GROUND: begin
								n_q        <= atgp_pkg::CNT_W'(n_clip);
								rd_cnt_q   <= '0;
								vld_s1     <= 1'b0;
								found_q    <= 1'b0;
								best_q     <= '0;
								best_top_q <= '0;
								state_q    <= ST_SCAN;
							end
							default: begin
								state_q <= ST_RD;
							end
						endcase
					end
				end
				ST_WR_NEW: begin
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					case (cmd_q)
						atgp_pkg::CMD_LOAD:  state_q <= ST_MERGE;
						atgp_pkg::CMD_CLASS: state_q <= ST_CLASS;
						atgp_pkg::CMD_PAIR:  state_q <= ST_RD2;
						default:             state_q <= ST_IDLE;
					endcase
				end
				ST_MERGE: begin
					state_q <= ST_IDLE;
				end
				ST_CLASS: begin
					res_q   <= {atgp_pkg::CMD_CLASS, 6'd0, 1'b0, cls, 1'b0};
					state_q <= ST_IDLE;
				end
				ST_RD2: begin
					pair_a_q <= ent;
					state_q  <= ST_PAIR;
				end
				ST_PAIR: begin
					res_q   <= {atgp_pkg::CMD_PAIR, 6'd0, 1'b0, atgp_pkg::CLS_NONE, &crsp.le};
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					vld_s1 <= issue;
					idx_s1 <= rd_cnt_q[atgp_pkg::IDX_W-1:0];
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (vld_s1 && qualify) begin
						found_q    <= 1'b1;
						best_q     <= idx_s1;
						best_top_q <= ent.hi[1];
					end
					if (!issue && !vld_s1) begin
						res_q   <= {atgp_pkg::CMD_GROUND, 6'(best_q), found_q,
							atgp_pkg::CLS_NONE, 1'b0};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ATGP_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
	`ATGP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`ATGP_ASSERT_NOW(a_kind_query, done, result.kind != atgp_pkg::CMD_LOAD, "result for a load")
	`ATGP_ASSERT_NOW(a_ground_only, done && result.kind != atgp_pkg::CMD_GROUND, !result.ground_found && result.ground_index == '0, "ground fields set outside a ground query")

endmodule
